// File: rtl/ite_pkg.sv
package ite_pkg;

  localparam int EPOCH_W = 39;
  localparam int ACC_W   = 40;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_NO_ZONE = 2'd2;

  // floor(y / 400) as (y * DIV400_MUL) >> DIV400_SHIFT, exact for y < 16384
  localparam logic signed [18:0] DIV400_MUL   = 19'sd20972;
  localparam int                 DIV400_SHIFT = 23;
  // floor(yoe / 100) as (yoe * DIV100_MUL) >> DIV100_SHIFT, exact for yoe < 400
  localparam logic signed [18:0] DIV100_MUL   = 19'sd41;
  localparam int                 DIV100_SHIFT = 12;

  localparam logic signed [18:0] YEAR_DAYS    = 19'sd365;
  localparam logic signed [18:0] ERA_YEARS    = 19'sd400;
  localparam logic signed [18:0] ERA_DAYS     = 19'sd146097;
  localparam logic signed [39:0] EPOCH_DAYS   = 40'sd719468;
  localparam logic signed [18:0] DAY_HOURS    = 19'sd24;
  localparam logic signed [18:0] HOUR_MINUTES = 19'sd60;
  localparam logic signed [18:0] HOUR_SECONDS = 19'sd3600;

  localparam logic [13:0] YEAR_MIN = 14'd1970;

  // one finished text, ready for the calendar arithmetic
  typedef struct packed {
    logic [13:0] year_adj;    // year, less one for January and February
    logic [3:0]  mp;          // month counted from March
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [4:0]  off_hours;
    logic [5:0]  off_minutes;
    logic        off_ahead;   // local time ahead of UTC: subtract the offset
    logic [1:0]  status;
  } job_t;

  // day of the March-based year on which month mp starts
  function automatic logic [8:0] doy_start(input logic [3:0] mp);
    logic [8:0] d;
    case (mp)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd61;
      4'd3:    d = 9'd92;
      4'd4:    d = 9'd122;
      4'd5:    d = 9'd153;
      4'd6:    d = 9'd184;
      4'd7:    d = 9'd214;
      4'd8:    d = 9'd245;
      4'd9:    d = 9'd275;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd337;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: rtl/ite_char_if.sv
interface ite_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// File: rtl/ite_epoch_if.sv
interface ite_epoch_if;
  logic               valid;
  logic               ready;
  logic signed [38:0] epoch_seconds;
  logic [1:0]         status;

  modport source (output valid, output epoch_seconds, output status, input ready);
  modport sink   (input valid, input epoch_seconds, input status, output ready);
endinterface

// File: rtl/iso8601_timestamp_to_epoch.sv
// ISO 8601 timestamp to Unix epoch seconds.
// in_chan carries one byte of the timestamp text per item, with is_last set
// on the final byte; out_chan carries one result per text: epoch_seconds
// (signed, UTC) and status (0 ok, 1 invalid text, 2 no zone marker).
// Both channels use valid/ready; an item moves when both are high.
// For each byte before the last the block keeps in_ready high.
// On the last byte the calendar conversion runs through one shared
// multiply-add unit for ten steps; out_valid rises once the result has
// moved into a free output register, and in_ready stays low from the cycle
// after the last byte until the result has moved into the output register.
// A result waiting on a stalled receiver is held in the output register; a
// second result stays in the arithmetic unit, which keeps in_ready low.
// Synchronous reset clears the parser, the sequencer and out_valid.
module iso8601_timestamp_to_epoch (
  input logic         clk,
  input logic         rst_n,
  ite_char_if.sink    in_chan,
  ite_epoch_if.source out_chan
);

  localparam logic [4:0] FIXED_LEN = 5'd19;
  localparam logic [2:0] ZONE_LEN  = 3'd6;

  localparam logic [1:0] ZONE_NONE   = 2'd0;
  localparam logic [1:0] ZONE_UTC    = 2'd1;
  localparam logic [1:0] ZONE_AHEAD  = 2'd2;
  localparam logic [1:0] ZONE_BEHIND = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  function automatic logic [6:0] acc2(input logic [6:0] a, input logic [3:0] d);
    return 7'({a, 3'b000} + {a, 1'b0} + 10'(d));
  endfunction

  logic [4:0]  pos_r, pos_nxt;
  logic [13:0] year_r, year_nxt;
  logic [6:0]  month_r, month_nxt, day_r, day_nxt, hour_r, hour_nxt;
  logic [6:0]  minute_r, minute_nxt, second_r, second_nxt;
  logic        digit_err_r, digit_err_nxt;
  logic [1:0]  zone_kind_r, zone_kind_nxt;
  logic [2:0]  zone_pos_r, zone_pos_nxt;
  logic [6:0]  oh_r, oh_nxt, om_r, om_nxt;
  logic        off_err_r, off_err_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic signed [38:0] out_epoch_r;
  logic [1:0]  out_status_r;

  logic [7:0]  c;
  logic [3:0]  dig;
  logic        is_dig, field, accept, start, fields_ok, offset_ok;
  logic [1:0]  status;
  logic [3:0]  mp;
  ite_pkg::job_t job;

  logic               calc_busy, calc_done, load;
  logic signed [38:0] calc_epoch;
  logic [1:0]         calc_status;

  assign c      = in_chan.char_code;
  assign dig    = c[3:0];
  assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
  assign field  = !((pos_r == 5'd4) || (pos_r == 5'd7) || (pos_r == 5'd10) ||
                    (pos_r == 5'd13) || (pos_r == 5'd16));

  assign in_chan.ready = !calc_busy;
  assign accept        = in_chan.valid && !calc_busy;
  assign start         = accept && in_chan.is_last;

  always_comb begin
    pos_nxt       = pos_r;
    year_nxt      = year_r;
    month_nxt     = month_r;
    day_nxt       = day_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    second_nxt    = second_r;
    digit_err_nxt = digit_err_r;
    zone_kind_nxt = zone_kind_r;
    zone_pos_nxt  = zone_pos_r;
    oh_nxt        = oh_r;
    om_nxt        = om_r;
    off_err_nxt   = off_err_r;
    if (pos_r < FIXED_LEN) begin
      pos_nxt = pos_r + 5'd1;
      if (field) begin
        if (!is_dig) begin
          digit_err_nxt = 1'b1;
        end else if (pos_r <= 5'd3) begin
          year_nxt = 14'({year_r, 3'b000} + {year_r, 1'b0} + 17'(dig));
        end else if (pos_r <= 5'd6) begin
          month_nxt = acc2(month_r, dig);
        end else if (pos_r <= 5'd9) begin
          day_nxt = acc2(day_r, dig);
        end else if (pos_r <= 5'd12) begin
          hour_nxt = acc2(hour_r, dig);
        end else if (pos_r <= 5'd15) begin
          minute_nxt = acc2(minute_r, dig);
        end else begin
          second_nxt = acc2(second_r, dig);
        end
      end
    end else if (zone_kind_r == ZONE_NONE) begin
      // skip bytes up to the zone marker
      if (c == CH_Z) begin
        zone_kind_nxt = ZONE_UTC;
        zone_pos_nxt  = 3'd1;
      end else if (c == CH_PLUS) begin
        zone_kind_nxt = ZONE_AHEAD;
        zone_pos_nxt  = 3'd1;
      end else if (c == CH_MINUS) begin
        zone_kind_nxt = ZONE_BEHIND;
        zone_pos_nxt  = 3'd1;
      end
    end else if ((zone_kind_r != ZONE_UTC) && (zone_pos_r < ZONE_LEN)) begin
      zone_pos_nxt = zone_pos_r + 3'd1;
      if (zone_pos_r == 3'd3) begin
        if (c != CH_COLON) off_err_nxt = 1'b1;
      end else if (!is_dig) begin
        off_err_nxt = 1'b1;
      end else if (zone_pos_r <= 3'd2) begin
        oh_nxt = acc2(oh_r, dig);
      end else begin
        om_nxt = acc2(om_r, dig);
      end
    end
  end

  // verdict on the text as it stands after the last byte
  always_comb begin
    fields_ok = (pos_r >= FIXED_LEN - 5'd1) && !digit_err_nxt &&
                (year_nxt >= ite_pkg::YEAR_MIN) &&
                (month_nxt >= 7'd1) && (month_nxt <= 7'd12) &&
                (day_nxt >= 7'd1) && (day_nxt <= 7'd31) && (hour_nxt <= 7'd23) &&
                (minute_nxt <= 7'd59) && (second_nxt <= 7'd60);
    offset_ok = (zone_pos_nxt >= ZONE_LEN) && !off_err_nxt &&
                (oh_nxt <= 7'd23) && (om_nxt <= 7'd59);
    if (!fields_ok) begin
      status = ite_pkg::STATUS_INVALID;
    end else if (zone_kind_nxt == ZONE_NONE) begin
      status = ite_pkg::STATUS_NO_ZONE;
    end else if ((zone_kind_nxt == ZONE_UTC) || offset_ok) begin
      status = ite_pkg::STATUS_OK;
    end else begin
      status = ite_pkg::STATUS_INVALID;
    end
    mp = (month_nxt > 7'd2) ? (month_nxt[3:0] - 4'd3) : (month_nxt[3:0] + 4'd9);
    job.year_adj    = year_nxt - ((month_nxt <= 7'd2) ? 14'd1 : 14'd0);
    job.mp          = mp;
    job.day         = day_nxt[4:0];
    job.hour        = hour_nxt[4:0];
    job.minute      = minute_nxt[5:0];
    job.second      = second_nxt[5:0];
    job.off_hours   = (zone_kind_nxt == ZONE_UTC) ? 5'd0 : oh_nxt[4:0];
    job.off_minutes = (zone_kind_nxt == ZONE_UTC) ? 6'd0 : om_nxt[5:0];
    job.off_ahead   = (zone_kind_nxt == ZONE_AHEAD);
    job.status      = status;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      pos_r       <= '0;
      year_r      <= '0;
      month_r     <= '0;
      day_r       <= '0;
      hour_r      <= '0;
      minute_r    <= '0;
      second_r    <= '0;
      digit_err_r <= 1'b0;
      zone_kind_r <= ZONE_NONE;
      zone_pos_r  <= '0;
      oh_r        <= '0;
      om_r        <= '0;
      off_err_r   <= 1'b0;
    end else if (accept) begin
      pos_r       <= pos_nxt;
      year_r      <= year_nxt;
      month_r     <= month_nxt;
      day_r       <= day_nxt;
      hour_r      <= hour_nxt;
      minute_r    <= minute_nxt;
      second_r    <= second_nxt;
      digit_err_r <= digit_err_nxt;
      zone_kind_r <= zone_kind_nxt;
      zone_pos_r  <= zone_pos_nxt;
      oh_r        <= oh_nxt;
      om_r        <= om_nxt;
      off_err_r   <= off_err_nxt;
    end
  end

  ite_calc u_calc (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .job    (job),
    .busy   (calc_busy),
    .done   (calc_done),
    .take   (load),
    .epoch  (calc_epoch),
    .status (calc_status)
  );

  // move the result into the output register once it is free
  assign load = calc_done && (!out_valid_r || out_chan.ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_epoch_r  <= calc_epoch;
      out_status_r <= calc_status;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.epoch_seconds = out_epoch_r;
  assign out_chan.status        = out_status_r;

endmodule

// File: rtl/ite_calc.sv
module ite_calc (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ite_pkg::job_t      job,
  output logic               busy,
  output logic               done,
  input  logic               take,
  output logic signed [38:0] epoch,
  output logic [1:0]         status
);

  localparam logic [3:0] STEP_IDLE    = 4'd0;
  localparam logic [3:0] STEP_DIV400  = 4'd1;
  localparam logic [3:0] STEP_YOE     = 4'd2;
  localparam logic [3:0] STEP_DIV100  = 4'd3;
  localparam logic [3:0] STEP_DOE     = 4'd4;
  localparam logic [3:0] STEP_DAYS    = 4'd5;
  localparam logic [3:0] STEP_HOURS   = 4'd6;
  localparam logic [3:0] STEP_MINUTES = 4'd7;
  localparam logic [3:0] STEP_SECONDS = 4'd8;
  localparam logic [3:0] STEP_OFF_H   = 4'd9;
  localparam logic [3:0] STEP_OFF_M   = 4'd10;
  localparam logic [3:0] STEP_DONE    = 4'd11;

  logic [3:0]          step_r, step_nxt;
  ite_pkg::job_t       job_r;
  logic [5:0]          era_r;
  logic [8:0]          yoe_r;
  logic signed [39:0]  acc_r, acc_nxt;
  logic signed [33:0]  op_a;
  logic signed [18:0]  op_b;
  logic signed [39:0]  op_c;
  logic signed [52:0]  product;
  logic [39:0]         base_doe;
  logic                compute;

  assign compute = (step_r != STEP_IDLE) && (step_r != STEP_DONE);

  assign base_doe = 40'(yoe_r[8:2]) - 40'(acc_r[13:12]) + 40'(ite_pkg::doy_start(job_r.mp))
                  + 40'(job_r.day) - 40'd1;

  // operand selection for the shared multiply-add
  always_comb begin
    op_a = '0;
    op_b = '0;
    op_c = acc_r;
    case (step_r)
      STEP_DIV400: begin
        op_a = $signed(34'(job_r.year_adj));
        op_b = ite_pkg::DIV400_MUL;
        op_c = '0;
      end
      STEP_YOE: begin
        op_a = $signed(34'(acc_r[28:23]));
        op_b = -ite_pkg::ERA_YEARS;
        op_c = $signed(40'(job_r.year_adj));
      end
      STEP_DIV100: begin
        op_a = $signed(34'(acc_r[8:0]));
        op_b = ite_pkg::DIV100_MUL;
        op_c = '0;
      end
      STEP_DOE: begin
        op_a = $signed(34'(yoe_r));
        op_b = ite_pkg::YEAR_DAYS;
        op_c = $signed(base_doe);
      end
      STEP_DAYS: begin
        op_a = $signed(34'(era_r));
        op_b = ite_pkg::ERA_DAYS;
        op_c = acc_r - ite_pkg::EPOCH_DAYS;
      end
      STEP_HOURS: begin
        op_a = $signed(acc_r[33:0]);
        op_b = ite_pkg::DAY_HOURS;
        op_c = $signed(40'(job_r.hour));
      end
      STEP_MINUTES: begin
        op_a = $signed(acc_r[33:0]);
        op_b = ite_pkg::HOUR_MINUTES;
        op_c = $signed(40'(job_r.minute));
      end
      STEP_SECONDS: begin
        op_a = $signed(acc_r[33:0]);
        op_b = ite_pkg::HOUR_MINUTES;
        op_c = $signed(40'(job_r.second));
      end
      STEP_OFF_H: begin
        op_a = $signed(34'(job_r.off_hours));
        op_b = job_r.off_ahead ? -ite_pkg::HOUR_SECONDS : ite_pkg::HOUR_SECONDS;
      end
      STEP_OFF_M: begin
        op_a = $signed(34'(job_r.off_minutes));
        op_b = job_r.off_ahead ? -ite_pkg::HOUR_MINUTES : ite_pkg::HOUR_MINUTES;
      end
      default: begin
        op_a = '0;
        op_b = '0;
        op_c = acc_r;
      end
    endcase
  end

  assign product = op_a * op_b;
  assign acc_nxt = op_c + $signed(product[39:0]);

  always_comb begin
    step_nxt = step_r;
    case (step_r)
      STEP_IDLE:  if (start) step_nxt = STEP_DIV400;
      STEP_OFF_M: step_nxt = STEP_DONE;
      STEP_DONE:  if (take) step_nxt = STEP_IDLE;
      default:    step_nxt = step_r + 4'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && (step_r == STEP_IDLE)) job_r <= job;
    if (compute) acc_r <= acc_nxt;
    if (step_r == STEP_YOE) era_r <= acc_r[28:23];
    if (step_r == STEP_DIV100) yoe_r <= acc_r[8:0];
  end

  assign busy   = (step_r != STEP_IDLE);
  assign done   = (step_r == STEP_DONE);
  assign status = job_r.status;
  assign epoch  = (job_r.status == ite_pkg::STATUS_OK) ? acc_r[38:0] : '0;

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int FIXED_LEN    = 19;
  localparam int ZONE_LEN     = 6;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {
    ZONE_NONE,
    ZONE_UTC,
    ZONE_AHEAD,
    ZONE_BEHIND
  } zone_kind_t;

  typedef struct {
    logic signed [ite_pkg::EPOCH_W-1:0] epoch_seconds;
    logic [1:0]                         status;
  } epoch_result_t;

  logic clk;
  logic rst_n;

  ite_char_if  in_if ();
  ite_epoch_if out_if ();

  iso8601_timestamp_to_epoch i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // parser state of the predictor
  logic [5:0]  char_pos;
  logic [13:0] year_acc;
  logic [6:0]  month_acc, day_acc, hour_acc, minute_acc, second_acc;
  logic        field_bad;
  zone_kind_t  zone_kind;
  logic [2:0]  zone_pos;
  logic [6:0]  off_hours_acc, off_minutes_acc;
  logic        offset_bad;

  epoch_result_t pending_epochs [$];
  epoch_result_t got_front;
  logic [7:0]    text_buf [$];

  int idle_pct;
  int stall_pct;
  int error_count;
  int bytes_sent;
  int texts_sent;
  int results_checked;
  int cycle_count;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic longint days_from_civil(input longint year, input longint month,
                                             input longint day);
    longint y, era, yoe, mp, doy, doe;
    y   = (month <= 2) ? year - 1 : year;
    era = y / 400;
    yoe = y - era * 400;
    mp  = (month > 2) ? month - 3 : month + 9;
    doy = (153 * mp + 2) / 5 + day - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  task automatic clear_parser();
    char_pos        = '0;
    year_acc        = '0;
    month_acc       = '0;
    day_acc         = '0;
    hour_acc        = '0;
    minute_acc      = '0;
    second_acc      = '0;
    field_bad       = 1'b0;
    zone_kind       = ZONE_NONE;
    zone_pos        = '0;
    off_hours_acc   = '0;
    off_minutes_acc = '0;
    offset_bad      = 1'b0;
  endtask

  // Advance the predictor by one accepted byte; queue the result on the last one.
  task automatic parse_byte(input logic [7:0] c, input logic last);
    logic [5:0]    p;
    logic [3:0]    d;
    logic          ok;
    longint        t, off, hh, mi, ss;
    epoch_result_t res;
    p = char_pos;
    d = c[3:0];
    if (p < FIXED_LEN) begin
      if (!(p == 4 || p == 7 || p == 10 || p == 13 || p == 16)) begin
        if (!is_digit(c)) field_bad = 1'b1;
        else if (p <= 3) year_acc = year_acc * 14'd10 + 14'(d);
        else if (p <= 6) month_acc = month_acc * 7'd10 + 7'(d);
        else if (p <= 9) day_acc = day_acc * 7'd10 + 7'(d);
        else if (p <= 12) hour_acc = hour_acc * 7'd10 + 7'(d);
        else if (p <= 15) minute_acc = minute_acc * 7'd10 + 7'(d);
        else second_acc = second_acc * 7'd10 + 7'(d);
      end
    end else if (zone_kind == ZONE_NONE) begin
      if (c == "Z") begin
        zone_kind = ZONE_UTC;
        zone_pos  = 3'd1;
      end else if (c == "+") begin
        zone_kind = ZONE_AHEAD;
        zone_pos  = 3'd1;
      end else if (c == "-") begin
        zone_kind = ZONE_BEHIND;
        zone_pos  = 3'd1;
      end
    end else if (zone_kind != ZONE_UTC && zone_pos < ZONE_LEN) begin
      if (zone_pos == 3) begin
        if (c != ":") offset_bad = 1'b1;
      end else if (!is_digit(c)) begin
        offset_bad = 1'b1;
      end else if (zone_pos <= 2) begin
        off_hours_acc = off_hours_acc * 7'd10 + 7'(d);
      end else begin
        off_minutes_acc = off_minutes_acc * 7'd10 + 7'(d);
      end
      zone_pos = zone_pos + 3'd1;
    end
    if (char_pos < FIXED_LEN) char_pos = char_pos + 6'd1;

    if (last) begin
      res.epoch_seconds = '0;
      res.status        = ite_pkg::STATUS_INVALID;
      ok = (p >= FIXED_LEN - 1) && !field_bad && year_acc >= 14'd1970 &&
           month_acc >= 7'd1 && month_acc <= 7'd12 && day_acc >= 7'd1 &&
           day_acc <= 7'd31 && hour_acc <= 7'd23 && minute_acc <= 7'd59 &&
           second_acc <= 7'd60;
      if (ok) begin
        hh = hour_acc;
        mi = minute_acc;
        ss = second_acc;
        t  = days_from_civil(year_acc, month_acc, day_acc) * 86400 + hh * 3600 + mi * 60 + ss;
        hh  = off_hours_acc;
        mi  = off_minutes_acc;
        off = hh * 3600 + mi * 60;
        case (zone_kind)
          ZONE_NONE: begin
            res.status = ite_pkg::STATUS_NO_ZONE;
          end
          ZONE_UTC: begin
            res.status        = ite_pkg::STATUS_OK;
            res.epoch_seconds = t[ite_pkg::EPOCH_W-1:0];
          end
          default: begin
            if (zone_pos >= ZONE_LEN && !offset_bad && off_hours_acc <= 7'd23 &&
                off_minutes_acc <= 7'd59) begin
              t = (zone_kind == ZONE_AHEAD) ? t - off : t + off;
              res.status        = ite_pkg::STATUS_OK;
              res.epoch_seconds = t[ite_pkg::EPOCH_W-1:0];
            end
          end
        endcase
      end
      pending_epochs.push_back(res);
      clear_parser();
    end
  endtask

  // Offer one byte, idling beforehand at the current rate; returns once taken.
  task automatic send_byte(input logic [7:0] c, input logic last);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.char_code <= c;
    in_if.is_last   <= last;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    parse_byte(c, last);
    bytes_sent++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      send_byte(text_buf[i], i == text_buf.size() - 1);
    texts_sent++;
    text_buf.delete();
  endtask

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endfunction

  function automatic void add_num(input int v, input int digits);
    int div;
    div = 1;
    repeat (digits - 1) div *= 10;
    for (int i = 0; i < digits; i++) begin
      text_buf.push_back(8'("0" + (v / div) % 10));
      div /= 10;
    end
  endfunction

  task automatic send_str(input string s);
    add_str(s);
    send_text();
  endtask

  // Mostly in range, now and then out of it.
  function automatic int field_value(input int lo, input int hi, input int bad_lo,
                                     input int bad_hi);
    if ($urandom_range(0, 99) < 5) return $urandom_range(bad_lo, bad_hi);
    return $urandom_range(lo, hi);
  endfunction

  function automatic logic [7:0] any_sep(input logic [7:0] usual);
    if ($urandom_range(0, 99) < 10) return 8'($urandom_range(0, 255));
    return usual;
  endfunction

  function automatic logic [7:0] skip_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == "Z" || b == "+" || b == "-") b = "x";
    return b;
  endfunction

  task automatic build_timestamp();
    int         n, k, zs;
    logic [7:0] b;
    n = ($urandom_range(0, 99) < 5) ? $urandom_range(1000, 1969) : $urandom_range(1970, 9999);
    add_num(n, 4);
    text_buf.push_back(any_sep("-"));
    add_num(field_value(1, 12, 0, 99), 2);
    text_buf.push_back(any_sep("-"));
    add_num(field_value(1, 31, 0, 99), 2);
    text_buf.push_back(any_sep("T"));
    add_num(field_value(0, 23, 24, 99), 2);
    text_buf.push_back(any_sep(":"));
    add_num(field_value(0, 59, 60, 99), 2);
    text_buf.push_back(any_sep(":"));
    add_num(field_value(0, 60, 61, 99), 2);
    if ($urandom_range(0, 99) < 5) begin
      k = $urandom_range(0, FIXED_LEN - 1);
      b = 8'($urandom_range(0, 255));
      if (is_digit(b)) b = "?";
      if (!(k == 4 || k == 7 || k == 10 || k == 13 || k == 16)) text_buf[k] = b;
    end
    // fraction or other bytes that the block skips before the zone
    if ($urandom_range(0, 99) < 20) begin
      text_buf.push_back(".");
      add_num($urandom_range(0, 999999), $urandom_range(1, 6));
    end
    if ($urandom_range(0, 99) < 10) repeat ($urandom_range(1, 5)) text_buf.push_back(skip_byte());
    k = $urandom_range(0, 99);
    if (k < 30) begin
      text_buf.push_back("Z");
    end else if (k < 90) begin
      text_buf.push_back((k < 60) ? "+" : "-");
      zs = text_buf.size();
      add_num(field_value(0, 23, 24, 99), 2);
      text_buf.push_back(($urandom_range(0, 99) < 95) ? ":" : 8'($urandom_range(0, 255)));
      add_num(field_value(0, 59, 60, 99), 2);
      if ($urandom_range(0, 99) < 5) text_buf[zs + $urandom_range(0, 4)] = "a";
      if ($urandom_range(0, 99) < 5) repeat ($urandom_range(1, 4)) void'(text_buf.pop_back());
    end
    if ($urandom_range(0, 99) < 15)
      repeat ($urandom_range(1, 4)) text_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (pending_epochs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_valid_zones();
    send_str("1970-01-01T00:00:00Z");
    send_str("2026-07-26T23:18:00+02:00");
    send_str("2026-07-26T23:18:00-05:30");
    send_str("1970-01-01T00:00:00+23:59");
    send_str("9999-12-31T23:59:60-23:59");
    send_str("2000-02-29T12:00:00.123456Z");
    send_str("2023-02-31T00:00:00Z");
    send_str("2026/07/26 23:18:00Z");
  endtask

  task automatic test_field_limits();
    send_str("1969-12-31T23:59:59Z");
    send_str("2026-00-10T00:00:00Z");
    send_str("2026-13-01T00:00:00Z");
    send_str("2026-01-00T00:00:00Z");
    send_str("2026-01-32T24:60:61Z");
    send_str("2026-07-2xT23:18:00Z");
    // a zero byte is a plain character, in a separator and in a field
    add_str("2026-07-26");
    text_buf.push_back(8'h00);
    add_str("23:18:00Z");
    send_text();
    add_str("2026-07-26T23:1");
    text_buf.push_back(8'h00);
    add_str(":00Z");
    send_text();
  endtask

  task automatic test_offset_errors();
    send_str("2026-07-26T23:18:00+02:0");
    send_str("2026-07-26T23:18:00+0200");
    send_str("2026-07-26T23:18:00-24:00");
    send_str("2026-07-26T23:18:00+02:60");
    send_str("2026-07-26T23:18:00+0a:00");
  endtask

  task automatic test_length_and_skipping();
    send_str("2026-07-26T23:18:00");
    send_str("2026-07-26T23:18:0");
    send_str("1");
    send_str("2026-07-26T23:18:00 utc Z+01:00");
    send_str("2026-07-26T23:18:00+01:00:99-03");
  endtask

  // Mostly well-formed timestamps with random content, the rest cut short or noise.
  task automatic test_random_texts(input int byte_target, input int text_target);
    int start_bytes, start_texts, kind, n;
    start_bytes = bytes_sent;
    start_texts = texts_sent;
    while (bytes_sent - start_bytes < byte_target || texts_sent - start_texts < text_target) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        build_timestamp();
      end else if (kind < 90) begin
        build_timestamp();
        n = $urandom_range(1, text_buf.size());
        while (text_buf.size() > n) void'(text_buf.pop_back());
      end else begin
        repeat ($urandom_range(1, 40)) text_buf.push_back(8'($urandom_range(0, 255)));
      end
      send_text();
    end
  endtask

  always @(posedge clk) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_epochs.size() == 0) begin
        $display("%0t: result with none expected: epoch %0d status %0d", $time,
                 out_if.epoch_seconds, out_if.status);
        error_count++;
      end else begin
        got_front = pending_epochs.pop_front();
        results_checked++;
        if (out_if.epoch_seconds !== got_front.epoch_seconds) begin
          $display("%0t: epoch_seconds expected %0d, got %0d", $time,
                   got_front.epoch_seconds, out_if.epoch_seconds);
          error_count++;
        end
        if (out_if.status !== got_front.status) begin
          $display("%0t: status expected %0d, got %0d", $time, got_front.status, out_if.status);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_epochs.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.char_code = '0;
    in_if.is_last   = 1'b0;
    out_if.ready    = 1'b0;
    idle_pct        = 0;
    stall_pct       = 0;
    error_count     = 0;
    bytes_sent      = 0;
    texts_sent      = 0;
    results_checked = 0;
    cycle_count     = 0;
    clear_parser();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_valid_zones();
    test_field_limits();
    test_offset_errors();
    test_length_and_skipping();
    test_random_texts(270, 10);
    wait_drained();

    idle_pct  = 66;
    stall_pct = 0;
    test_random_texts(270, 10);
    wait_drained();

    idle_pct  = 0;
    stall_pct = 66;
    test_random_texts(270, 10);
    wait_drained();

    idle_pct  = 38;
    stall_pct = 38;
    test_random_texts(270, 10);
    wait_drained();

    $display("tb: %0d texts of %0d bytes sent, %0d results checked", texts_sent, bytes_sent,
             results_checked);
    $display("tb: zones, offsets, field limits, short texts and noise under four idling mixes");
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ite_pkg.sv
rtl/ite_char_if.sv
rtl/ite_epoch_if.sv
rtl/ite_calc.sv
rtl/iso8601_timestamp_to_epoch.sv
tb/tb.sv
